### rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
`default_nettype none
package uer_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_END  = 3'd3,
    PH_WAIT_RISE = 3'd4,
    PH_WAIT_FALL = 3'd5
  } phase_t;

  typedef struct packed {
    logic drive_en;
    logic drive_lvl;
    logic busy;
    logic done;
    logic tmo;
  } flags_t;

  localparam int         TIMEOUT_W       = 24;
  localparam logic [23:0] TIMEOUT_RESET  = 24'd30000;
  localparam logic [2:0] TRIG_LOW_TICKS  = 3'd2;
  localparam logic [2:0] TRIG_HIGH_TICKS = 3'd5;
  localparam int         ECHO_DIVISOR    = 58;

endpackage
`default_nettype wire

### rtl/uer_seq.sv
// Trigger and echo timing sequencer: one state update per accepted tick.
`default_nettype none
module uer_seq
  import uer_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic                  cmd,
  input  wire logic                  echo_level,
  input  wire logic [TIMEOUT_W-1:0]  timeout_us,
  output flags_t                     flags,
  output logic [COUNT_BITS-1:0]      width
);

  localparam int CMP_W = (COUNT_BITS + 1 > TIMEOUT_W) ? COUNT_BITS + 1 : TIMEOUT_W;
  localparam logic [COUNT_BITS:0] ELAPSED_MAX = '1;

  phase_t                phase, phase_next, lph;
  logic [2:0]            ticks, ticks_next;
  logic [COUNT_BITS:0]   elapsed, elapsed_next;
  logic [COUNT_BITS-1:0] pulse_start, pulse_start_next;
  logic [COUNT_BITS-1:0] last_width, last_width_next;
  logic                  last_timeout, last_timeout_next;
  logic                  done, listen;
  logic [COUNT_BITS:0]   t, diff, wid;

  always_comb begin
    phase_next        = phase;
    ticks_next        = ticks;
    elapsed_next      = elapsed;
    pulse_start_next  = pulse_start;
    last_width_next   = last_width;
    last_timeout_next = last_timeout;
    done              = 1'b0;
    listen            = 1'b0;
    t                 = elapsed;
    lph               = phase;
    diff              = '0;
    wid               = '0;
    case (phase)
      PH_TRIG_LOW: begin
        if (ticks >= TRIG_LOW_TICKS) begin
          phase_next = PH_TRIG_HIGH;
          ticks_next = 3'd1;
        end else begin
          ticks_next = ticks + 3'd1;
        end
      end
      PH_TRIG_HIGH: begin
        if (ticks >= TRIG_HIGH_TICKS) begin
          phase_next = PH_WAIT_END;
          ticks_next = '0;
          t          = '0;
          listen     = 1'b1;
        end else begin
          ticks_next = ticks + 3'd1;
        end
      end
      PH_WAIT_END, PH_WAIT_RISE, PH_WAIT_FALL: begin
        listen = 1'b1;
      end
      default: begin
        phase_next = PH_IDLE;
        ticks_next = '0;
        if (cmd) begin
          phase_next = PH_TRIG_LOW;
          ticks_next = 3'd1;
        end
      end
    endcase

    if (listen) begin
      elapsed_next = t;
      lph = phase_next;
      if (lph == PH_WAIT_END && !echo_level) begin
        lph = PH_WAIT_RISE;
      end
      if (lph == PH_WAIT_RISE && echo_level) begin
        pulse_start_next = t[COUNT_BITS] ? '1 : t[COUNT_BITS-1:0];
        lph = PH_WAIT_FALL;
      end
      diff = t - {1'b0, pulse_start_next};
      wid  = (t >= {1'b0, pulse_start_next}) ? diff : '0;
      if (lph == PH_WAIT_FALL && !echo_level) begin
        last_width_next   = wid[COUNT_BITS] ? '1 : wid[COUNT_BITS-1:0];
        last_timeout_next = 1'b0;
        phase_next        = PH_IDLE;
        ticks_next        = '0;
        done              = 1'b1;
      end else if (CMP_W'(t) > CMP_W'(timeout_us)) begin
        last_width_next   = '0;
        last_timeout_next = 1'b1;
        phase_next        = PH_IDLE;
        ticks_next        = '0;
        done              = 1'b1;
      end else begin
        phase_next   = lph;
        elapsed_next = (t == ELAPSED_MAX) ? t : t + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      ticks        <= '0;
      elapsed      <= '0;
      pulse_start  <= '0;
      last_width   <= '0;
      last_timeout <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      ticks        <= ticks_next;
      elapsed      <= elapsed_next;
      pulse_start  <= pulse_start_next;
      last_width   <= last_width_next;
      last_timeout <= last_timeout_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flags.drive_en  <= (phase_next == PH_TRIG_LOW) || (phase_next == PH_TRIG_HIGH);
      flags.drive_lvl <= (phase_next == PH_TRIG_HIGH);
      flags.busy      <= (phase_next != PH_IDLE);
      flags.done      <= done;
      flags.tmo       <= last_timeout_next;
      width           <= last_width_next;
    end
  end

endmodule
`default_nettype wire

### rtl/uer_div.sv
// Distance pipeline: width * 2^FRACTION_BITS / 58 by reciprocal multiply and correction.
`default_nettype none
module uer_div
  import uer_pkg::*;
#(
  parameter int COUNT_BITS    = 24,
  parameter int FRACTION_BITS = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  adv,
  input  wire flags_t                                flags_in,
  input  wire logic [COUNT_BITS-1:0]                 width_in,
  output flags_t                                     flags_out,
  output logic [COUNT_BITS-1:0]                      width_out,
  output logic [COUNT_BITS+FRACTION_BITS-6:0]        distance
);

  localparam int K      = COUNT_BITS + 6;
  localparam int M_W    = COUNT_BITS + 1;
  localparam int Q_W    = COUNT_BITS - 5;
  localparam int DIST_W = COUNT_BITS + FRACTION_BITS - 5;
  localparam int FRAC_W = (FRACTION_BITS > 0) ? FRACTION_BITS : 1;
  localparam logic [M_W-1:0] RECIP = M_W'((64'd1 << K) / ECHO_DIVISOR);
  localparam logic [6:0] DIV7 = 7'(ECHO_DIVISOR);

  typedef logic [ECHO_DIVISOR-1:0][FRAC_W-1:0] frac_tab_t;

  // fraction of r/58 for every remainder r below 58
  function automatic frac_tab_t frac_table();
    frac_tab_t tab;
    for (int i = 0; i < ECHO_DIVISOR; i++) begin
      tab[i] = FRAC_W'((i << FRACTION_BITS) / ECHO_DIVISOR);
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = frac_table();

  flags_t                        flags2, flags3;
  logic [COUNT_BITS-1:0]         width2, width3;
  logic [COUNT_BITS+M_W-1:0]     prod;
  logic [Q_W-1:0]                q_est, q_fix, q3;
  logic [6:0]                    qm, r_est;
  logic [5:0]                    r_fix, r3;
  logic [FRAC_W-1:0]             frac;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod   <= width_in * RECIP;
      width2 <= width_in;
      flags2 <= flags_in;
    end
  end

  assign q_est = prod[K +: Q_W];
  assign qm    = q_est[6:0] * DIV7;
  assign r_est = width2[6:0] - qm;

  always_comb begin
    if (r_est >= DIV7) begin
      q_fix = q_est + 1'b1;
      r_fix = 6'(r_est - DIV7);
    end else begin
      q_fix = q_est;
      r_fix = r_est[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q3     <= q_fix;
      r3     <= r_fix;
      width3 <= width2;
      flags3 <= flags2;
    end
  end

  assign frac = FRAC_TAB[r3];

  always_ff @(posedge clk) begin
    if (adv) begin
      distance  <= (DIST_W'(q3) << FRACTION_BITS) + DIST_W'(frac);
      width_out <= width3;
      flags_out <= flags3;
    end
  end

endmodule
`default_nettype wire

### rtl/ultrasonic_echo_ranger.sv
// Top level of the single-pin ultrasonic echo ranger.
// Usage:
//   Input channel (in_valid/in_stall) carries one microsecond tick per request:
//   cmd starts a measurement when idle, echo_level is the sampled pin level.
//   Output channel (out_valid/out_stall) returns exactly one result per request:
//   pin drive enable and level, busy, done pulse, timeout flag, last distance
//   (cm, FRACTION_BITS fraction bits) and last echo width in ticks.
//   cfg_we/cfg_wdata write the timeout in ticks; write only while idle.
// Timing:
//   One request per clock cycle sustained while no result is stalled. Each
//   result passes the sequencer output register, then the reciprocal multiply,
//   the quotient correction and the fraction lookup stages of the distance pipeline.
// Reset:
//   rst (synchronous) empties the pipeline, returns the sequencer to idle,
//   clears the stored width and timeout flag, and loads the timeout register
//   with 30000.
// Stall:
//   While out_stall holds a waiting result, the whole pipeline freezes and
//   in_stall is raised; nothing is lost or repeated.
`default_nettype none
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int COUNT_BITS    = 24,
  parameter int FRACTION_BITS = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [TIMEOUT_W-1:0]               cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               cmd,
  input  wire logic                               echo_level,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    pin_drive_enable,
  output logic                                    pin_drive_level,
  output logic                                    busy_res,
  output logic                                    measure_done,
  output logic                                    timed_out,
  output logic [COUNT_BITS+FRACTION_BITS-6:0]     distance_q4,
  output logic [COUNT_BITS-1:0]                   echo_width_us
);

  logic [TIMEOUT_W-1:0]  timeout_us;
  logic                  adv, accept;
  logic [2:0]            stage_valid;
  flags_t                seq_flags, out_flags;
  logic [COUNT_BITS-1:0] seq_width;

  assign in_stall = out_valid && out_stall;
  assign adv      = !in_stall;
  assign accept   = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_us <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      stage_valid <= {stage_valid[1:0], in_valid};
      out_valid   <= stage_valid[2];
    end
  end

  uer_seq #(
    .COUNT_BITS(COUNT_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd),
    .echo_level (echo_level),
    .timeout_us (timeout_us),
    .flags      (seq_flags),
    .width      (seq_width)
  );

  uer_div #(
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk       (clk),
    .adv       (adv),
    .flags_in  (seq_flags),
    .width_in  (seq_width),
    .flags_out (out_flags),
    .width_out (echo_width_us),
    .distance  (distance_q4)
  );

  assign pin_drive_enable = out_flags.drive_en;
  assign pin_drive_level  = out_flags.drive_lvl;
  assign busy_res         = out_flags.busy;
  assign measure_done     = out_flags.done;
  assign timed_out        = out_flags.tmo;

endmodule
`default_nettype wire

### rtl/uer_checker.sv
// Port-level checks for the ultrasonic echo ranger, bound to the top level.
`default_nettype none
module uer_checker
  import uer_pkg::*;
#(
  parameter int COUNT_BITS    = 24,
  parameter int FRACTION_BITS = 4
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic                               pin_drive_enable,
  input wire logic                               pin_drive_level,
  input wire logic                               busy_res,
  input wire logic                               measure_done,
  input wire logic                               timed_out,
  input wire logic [COUNT_BITS+FRACTION_BITS-6:0] distance_q4,
  input wire logic [COUNT_BITS-1:0]              echo_width_us
);

  // a finished measurement leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && measure_done |-> !busy_res && !pin_drive_enable)
    else $error("done with sequencer still busy");

  // timeout clears stored width and distance
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && timed_out |-> echo_width_us == '0 && distance_q4 == '0)
    else $error("timeout result carries a measurement");

  // pin only driven during a busy trigger phase, level low when released
  a_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!pin_drive_enable || busy_res) && (pin_drive_enable || !pin_drive_level))
    else $error("pin drive inconsistent");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance_q4) && $stable(echo_width_us)
      && $stable(measure_done) && $stable(timed_out) && $stable(busy_res))
    else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger uer_checker #(
  .COUNT_BITS    (COUNT_BITS),
  .FRACTION_BITS (FRACTION_BITS)
) u_uer_checker (.*);
`default_nettype wire
